[rtl/achs_pkg.sv]
package achs_pkg;

   // Parser phases
   typedef enum logic [2:0] {
      PH_PREFIX    = 3'd0,
      PH_ID3_HDR   = 3'd1,
      PH_ID3_SKIP  = 3'd2,
      PH_FLAC_HDR  = 3'd3,
      PH_FLAC_SKIP = 3'd4,
      PH_PASS      = 3'd5,
      PH_DEAD      = 3'd6
   } phase_type;

   // Result status codes
   localparam logic [1:0] ST_PAYLOAD = 2'd0;
   localparam logic [1:0] ST_SKIPPED = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;

   // Marker characters
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_3      = 8'h33;
   localparam logic [7:0] CH_F_LOW  = 8'h66;
   localparam logic [7:0] CH_L      = 8'h4C;
   localparam logic [7:0] CH_A_LOW  = 8'h61;
   localparam logic [7:0] CH_C      = 8'h43;

   // Header layout constants
   localparam logic [7:0]  SYNCSAFE_MASK   = 8'h7F;
   localparam logic [7:0]  FOOTER_FLAG     = 8'h10;
   localparam logic [7:0]  LAST_BLOCK_FLAG = 8'h80;
   localparam logic [28:0] ID3_HDR_LEN     = 29'd10;
   localparam logic [28:0] ID3_FOOTER_LEN  = 29'd10;
   localparam logic [23:0] ID3_FLAGS_POS   = 24'd5;
   localparam logic [23:0] ID3_SIZE_POS    = 24'd6;
   localparam logic [23:0] ID3_LAST_POS    = 24'd9;
   localparam logic [23:0] FLAC_BLK_HDR_LEN = 24'd4;
   localparam logic [23:0] LIMIT_RESET     = 24'd16384;

   // One group of results caused by one input beat
   typedef struct packed {
      logic [1:0]       status;
      logic [1:0]       last_idx;   // number of results minus one
      logic [3:0][7:0]  data;       // payload bytes, index 0 first
      logic [23:0]      length;     // skipped header length
   } group_type;

   // Expected marker byte at a given prefix position
   function automatic logic [7:0] marker_char(input logic [1:0] idx, input logic id3);
      logic [7:0] ch;
      case (idx)
         2'd0: ch = id3 ? CH_I : CH_F_LOW;
         2'd1: ch = id3 ? CH_D : CH_L;
         2'd2: ch = id3 ? CH_3 : CH_A_LOW;
         default: ch = CH_C;
      endcase
      return ch;
   endfunction

endpackage

[rtl/achs_front.sv]
module achs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_data_byte,
   input  logic              q_full,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [23:0]       csr_wdata,
   output logic              grp_valid,
   output achs_pkg::group_type grp
);
   import achs_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [23:0] pos_ff, pos_in;
   logic [23:0] skip_ff, skip_in;
   logic [27:0] acc_ff, acc_in;
   logic        footer_ff, footer_in;
   logic        final_ff, final_in;
   logic        is_id3_ff, is_id3_in;
   logic [23:0] limit_ff;

   logic        take;
   logic [7:0]  b;
   logic [23:0] pos_inc;
   logic [27:0] acc_id3;
   logic [23:0] acc_flac;
   logic [28:0] id3_total;
   logic        id3_over, id3_empty;
   logic [24:0] flac_end;
   logic        flac_over;
   logic        next_hdr_over;
   logic        skip_last;
   logic        marker_hit;
   logic        marker_id3;

   assign take      = req_push && !q_full;
   assign b         = req_data_byte;
   assign csr_ready = 1'b1;

   // Shared decode of the current beat
   always_comb begin
      pos_inc   = pos_ff + 24'd1;
      acc_id3   = {acc_ff[20:0], b[6:0] & SYNCSAFE_MASK[6:0]};
      acc_flac  = {acc_ff[15:0], b};
      id3_total = ID3_HDR_LEN + {1'b0, acc_id3} + (footer_ff ? ID3_FOOTER_LEN : 29'd0);
      id3_over  = id3_total > {5'd0, limit_ff};
      id3_empty = (acc_id3 == 28'd0) && !footer_ff;
      flac_end  = {1'b0, pos_inc} + {1'b0, acc_flac};
      if (final_ff) begin
         flac_over = flac_end > {1'b0, limit_ff};
      end else begin
         flac_over = ({1'b0, flac_end} + {2'd0, FLAC_BLK_HDR_LEN}) > {2'd0, limit_ff};
      end
      next_hdr_over = ({1'b0, pos_inc} + {1'b0, FLAC_BLK_HDR_LEN}) > {1'b0, limit_ff};
      skip_last     = skip_ff == 24'd1;
      marker_id3    = (pos_ff[1:0] == 2'd0) ? (b == CH_I) : is_id3_ff;
      marker_hit    = b == marker_char(pos_ff[1:0], marker_id3);
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_PREFIX: begin
            if (!marker_hit) begin
               phase_in = PH_PASS;
            end else if (pos_ff[1:0] == 2'd2 && is_id3_ff) begin
               phase_in = PH_ID3_HDR;
            end else if (pos_ff[1:0] == 2'd3) begin
               phase_in = next_hdr_over ? PH_DEAD : PH_FLAC_HDR;
            end
         end
         PH_ID3_HDR: begin
            if (pos_ff == ID3_LAST_POS) begin
               if (id3_over) begin
                  phase_in = PH_DEAD;
               end else if (id3_empty) begin
                  phase_in = PH_PASS;
               end else begin
                  phase_in = PH_ID3_SKIP;
               end
            end
         end
         PH_ID3_SKIP: begin
            if (skip_last) begin
               phase_in = PH_PASS;
            end
         end
         PH_FLAC_HDR: begin
            if (skip_last) begin
               if (flac_over) begin
                  phase_in = PH_DEAD;
               end else if (acc_flac == 24'd0) begin
                  phase_in = final_ff ? PH_PASS : PH_FLAC_HDR;
               end else begin
                  phase_in = PH_FLAC_SKIP;
               end
            end
         end
         PH_FLAC_SKIP: begin
            if (skip_last) begin
               if (final_ff) begin
                  phase_in = PH_PASS;
               end else begin
                  phase_in = next_hdr_over ? PH_DEAD : PH_FLAC_HDR;
               end
            end
         end
         PH_PASS: phase_in = PH_PASS;
         default: phase_in = PH_DEAD;
      endcase
   end

   // Datapath updates and emitted result group
   always_comb begin
      pos_in    = pos_ff;
      skip_in   = skip_ff;
      acc_in    = acc_ff;
      footer_in = footer_ff;
      final_in  = final_ff;
      is_id3_in = is_id3_ff;
      grp_valid = 1'b0;
      grp       = '0;
      case (phase_ff)
         PH_PREFIX: begin
            if (marker_hit) begin
               pos_in = pos_inc;
               if (pos_ff[1:0] == 2'd0) begin
                  is_id3_in = marker_id3;
               end
               if (pos_ff[1:0] == 2'd2 && is_id3_ff) begin
                  acc_in    = '0;
                  footer_in = 1'b0;
               end
               if (pos_ff[1:0] == 2'd3) begin
                  final_in = 1'b0;
                  if (next_hdr_over) begin
                     grp_valid  = 1'b1;
                     grp.status = ST_TOO_LONG;
                  end else begin
                     skip_in = FLAC_BLK_HDR_LEN;
                     acc_in  = '0;
                  end
               end
            end else begin
               // flush held marker bytes, then the breaking byte
               grp_valid    = 1'b1;
               grp.status   = ST_PAYLOAD;
               grp.last_idx = pos_ff[1:0];
               for (int k = 0; k < 4; k++) begin
                  grp.data[k] = (2'(k) < pos_ff[1:0]) ? marker_char(2'(k), is_id3_ff) : b;
               end
            end
         end
         PH_ID3_HDR: begin
            pos_in = pos_inc;
            if (pos_ff == ID3_FLAGS_POS) begin
               footer_in = (b & FOOTER_FLAG) != 8'd0;
            end
            if (pos_ff >= ID3_SIZE_POS) begin
               acc_in = acc_id3;
            end
            if (pos_ff == ID3_LAST_POS) begin
               if (id3_over) begin
                  grp_valid  = 1'b1;
                  grp.status = ST_TOO_LONG;
               end else if (id3_empty) begin
                  grp_valid  = 1'b1;
                  grp.status = ST_SKIPPED;
                  grp.length = pos_inc;
               end else begin
                  skip_in = 24'(id3_total - ID3_HDR_LEN);
               end
            end
         end
         PH_ID3_SKIP: begin
            pos_in  = pos_inc;
            skip_in = skip_ff - 24'd1;
            if (skip_last) begin
               grp_valid  = 1'b1;
               grp.status = ST_SKIPPED;
               grp.length = pos_inc;
            end
         end
         PH_FLAC_HDR: begin
            pos_in  = pos_inc;
            skip_in = skip_ff - 24'd1;
            if (skip_ff == FLAC_BLK_HDR_LEN) begin
               final_in = (b & LAST_BLOCK_FLAG) != 8'd0;
            end else begin
               acc_in = {4'd0, acc_flac};
            end
            if (skip_last) begin
               if (flac_over) begin
                  grp_valid  = 1'b1;
                  grp.status = ST_TOO_LONG;
               end else if (acc_flac == 24'd0) begin
                  if (final_ff) begin
                     grp_valid  = 1'b1;
                     grp.status = ST_SKIPPED;
                     grp.length = pos_inc;
                  end else begin
                     skip_in = FLAC_BLK_HDR_LEN;
                     acc_in  = '0;
                  end
               end else begin
                  skip_in = acc_flac;
               end
            end
         end
         PH_FLAC_SKIP: begin
            pos_in  = pos_inc;
            skip_in = skip_ff - 24'd1;
            if (skip_last) begin
               if (final_ff) begin
                  grp_valid  = 1'b1;
                  grp.status = ST_SKIPPED;
                  grp.length = pos_inc;
               end else if (next_hdr_over) begin
                  grp_valid  = 1'b1;
                  grp.status = ST_TOO_LONG;
               end else begin
                  skip_in = FLAC_BLK_HDR_LEN;
                  acc_in  = '0;
               end
            end
         end
         PH_PASS: begin
            grp_valid    = 1'b1;
            grp.status   = ST_PAYLOAD;
            grp.data[0]  = b;
         end
         default: begin
            grp_valid = 1'b0;
         end
      endcase
      if (!take) begin
         grp_valid = 1'b0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PREFIX;
         pos_ff    <= '0;
         skip_ff   <= '0;
         acc_ff    <= '0;
         footer_ff <= 1'b0;
         final_ff  <= 1'b0;
         is_id3_ff <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         skip_ff   <= skip_in;
         acc_ff    <= acc_in;
         footer_ff <= footer_in;
         final_ff  <= final_in;
         is_id3_ff <= is_id3_in;
      end
   end

   // Header size limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_wdata;
      end
   end

   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEAD) |-> !grp_valid)
      else $error("result emitted after header error");

   a_prefix_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PREFIX) |-> (pos_ff <= 24'd3))
      else $error("prefix position out of range");

   a_single_status: assert property (@(posedge clock) disable iff (reset)
      (grp_valid && grp.status != ST_PAYLOAD) |-> (grp.last_idx == 2'd0))
      else $error("status result group holds more than one result");

endmodule

[rtl/achs_queue.sv]
module achs_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  achs_pkg::group_type wr_data,
   output logic                full,
   input  logic                pop,
   output achs_pkg::group_type rd_data,
   output logic                empty
);
   import achs_pkg::*;

   localparam int AW = $clog2(DEPTH);

   group_type       mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]     count_ff;

   assign full    = count_ff == (AW+1)'(DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = mem[rd_ptr_ff];

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers and fill count; pointers wrap at the last entry
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (AW+1)'(1);
            2'b01:   count_ff <= count_ff - (AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("group queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("group queue underflow");

endmodule

[rtl/achs_back.sv]
module achs_back (
   input  logic                clock,
   input  logic                reset,
   input  achs_pkg::group_type head,
   input  logic                head_valid,
   output logic                head_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_out_byte,
   output logic [28:0]         rsp_skipped_length,
   output logic                rsp_last
);
   import achs_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff;
   logic [7:0]  out_byte_ff;
   logic [23:0] out_len_ff;
   logic        out_last_ff;
   logic        load;
   logic        is_last;

   // Load the output stage when a group is at the queue head and the stage is free or being drained
   assign load    = head_valid && (!out_valid_ff || rsp_pop);
   assign is_last = idx_ff == head.last_idx;
   assign head_pop = load && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output beat payload
   always_ff @(posedge clock) begin
      if (load) begin
         out_status_ff <= head.status;
         out_byte_ff   <= head.data[idx_ff];
         out_len_ff    <= head.length;
         out_last_ff   <= is_last;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_skipped_length = {5'd0, out_len_ff};
   assign rsp_last           = out_last_ff;

   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff <= head.last_idx))
      else $error("result index beyond group size");

endmodule

[rtl/audio_container_header_stripper.sv]
// Path: an accepted byte is queued as a result group, then loaded into the output
// register; a marker flush of up to four results follows one per cycle while popped.
// Throughput: one byte per cycle in pass-through while the queue has room; results
// go out one per cycle while rsp_pop is held, set by the single output register
// draining the group queue. Reset: synchronous, active high; returns to marker
// matching, empties the queue and output stage, and sets the header size limit to 16384.
module audio_container_header_stripper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic [28:0] rsp_skipped_length,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_wdata
);
   import achs_pkg::*;

   group_type grp, head;
   logic      grp_valid;
   logic      q_full, q_empty, head_pop;

   assign req_full = q_full;

   // Front: marker match and header walk
   achs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .grp_valid     (grp_valid),
      .grp           (grp)
   );

   // Queue of result groups between front and back
   achs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (grp_valid),
      .wr_data (grp),
      .full    (q_full),
      .pop     (head_pop),
      .rd_data (head),
      .empty   (q_empty)
   );

   // Back: one result beat per cycle while rsp_pop drains the output
   achs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .head_valid         (!q_empty),
      .head_pop           (head_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_status         (rsp_status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_skipped_length (rsp_skipped_length),
      .rsp_last           (rsp_last)
   );

endmodule

[dv/tb_audio_container_header_stripper.sv]
module tb_audio_container_header_stripper;
   timeunit 1ns;
   timeprecision 1ps;

   import achs_pkg::*;

   localparam int          SETTLE_CYCLES = 8;
   localparam int          ITEM_TARGET   = 320;
   localparam int          LONG_STALL    = 64;
   localparam logic [23:0] LIMIT_MAX     = 24'hFFFFFF;
   localparam logic [23:0] LIMIT_MIN     = 24'd10;

   typedef enum logic [2:0] {
      STREAM_ID3,
      STREAM_FLAC,
      STREAM_PLAIN,
      STREAM_OVERSIZE,
      STREAM_RANDOM
   } stream_kind_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_byte;
      logic [28:0] skipped_length;
      logic        last;
   } result_type;

   typedef struct packed {
      logic        is_write;   // row writes the limit instead of sending a byte
      logic [23:0] value;
      logic        typed;      // expected result given in the row itself
      result_type  want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_byte;
   logic [28:0] rsp_skipped_length;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [23:0] csr_wdata;

   // typed expectation travels with the beat
   logic        beat_typed;
   result_type  beat_want;

   // stripper state as predicted
   phase_type   parse_phase;
   logic [7:0]  marker_held [3];
   logic [28:0] hdr_pos;
   logic [28:0] skip_left;
   logic [27:0] size_acc;
   logic        footer_flag;
   logic        final_blk;
   logic [23:0] limit_bytes;

   result_type   step_out [4];
   int           step_count;
   result_type   due_results [$];
   stim_row_type stim_table [$];

   stream_kind_type stream_kind;
   int          mismatch_count  = 0;
   int          bytes_accepted  = 0;
   int          results_checked = 0;
   int          limit_writes    = 0;
   int          items_sent      = 0;
   int          send_burst_left = 0;
   int          rcv_burst_left  = 0;
   logic        stall_request   = 1'b0;

   audio_container_header_stripper i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_status         (rsp_status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_skipped_length (rsp_skipped_length),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   function automatic void add_result(input logic [1:0] st, input logic [7:0] ob,
                                      input logic [28:0] len);
      result_type r;
      r.status         = st;
      r.out_byte       = ob;
      r.skipped_length = len;
      r.last           = 1'b0;
      step_out[step_count] = r;
      step_count++;
   endfunction

   function automatic void header_too_long();
      parse_phase = PH_DEAD;
      add_result(ST_TOO_LONG, 8'd0, 29'd0);
   endfunction

   function automatic void header_done();
      parse_phase = PH_PASS;
      add_result(ST_SKIPPED, 8'd0, hdr_pos);
   endfunction

   // next FLAC block header starts at hdr_pos
   function automatic void open_flac_block();
      if ({3'd0, hdr_pos} + 32'd4 > {8'd0, limit_bytes}) begin
         header_too_long();
      end else begin
         parse_phase = PH_FLAC_HDR;
         skip_left   = 29'd4;
         size_acc    = 28'd0;
      end
   endfunction

   // marker broken: held bytes then the breaking byte go out in order
   function automatic void flush_marker(input int held, input logic [7:0] b);
      for (int i = 0; i < held; i++)
         add_result(ST_PAYLOAD, marker_held[i], 29'd0);
      add_result(ST_PAYLOAD, b, 29'd0);
      parse_phase = PH_PASS;
   endfunction

   function automatic void strip_byte(input logic [7:0] b);
      logic        want_id3;
      logic [31:0] total;
      logic [31:0] blk_end;
      logic [7:0]  low7;
      result_type  r;
      step_count = 0;
      want_id3 = (marker_held[0] == CH_I);
      case (parse_phase)
         PH_PREFIX: begin
            if (hdr_pos == 29'd0) begin
               if (b == CH_I || b == CH_F_LOW) begin
                  marker_held[0] = b;
                  hdr_pos = 29'd1;
               end else begin
                  flush_marker(0, b);
               end
            end else if (hdr_pos == 29'd1) begin
               if (b == (want_id3 ? CH_D : CH_L)) begin
                  marker_held[1] = b;
                  hdr_pos = 29'd2;
               end else begin
                  flush_marker(1, b);
               end
            end else if (hdr_pos == 29'd2) begin
               if (b == (want_id3 ? CH_3 : CH_A_LOW)) begin
                  marker_held[2] = b;
                  hdr_pos = 29'd3;
                  if (want_id3) begin
                     parse_phase = PH_ID3_HDR;
                     size_acc    = 28'd0;
                     footer_flag = 1'b0;
                  end
               end else begin
                  flush_marker(2, b);
               end
            end else begin
               if (b == CH_C) begin
                  hdr_pos   = 29'd4;
                  final_blk = 1'b0;
                  open_flac_block();
               end else begin
                  flush_marker(3, b);
               end
            end
         end
         // fixed ID3 header: flags at 5, syncsafe size at 6..9
         PH_ID3_HDR: begin
            if (hdr_pos == 29'd5)
               footer_flag = (b & FOOTER_FLAG) != 8'd0;
            if (hdr_pos >= 29'd6) begin
               low7     = b & SYNCSAFE_MASK;
               size_acc = {size_acc[20:0], low7[6:0]};
            end
            hdr_pos = hdr_pos + 29'd1;
            if (hdr_pos >= 29'd10) begin
               total = 32'd10 + {4'd0, size_acc} + (footer_flag ? 32'd10 : 32'd0);
               if (total > {8'd0, limit_bytes}) begin
                  header_too_long();
               end else if (total == 32'd10) begin
                  header_done();
               end else begin
                  skip_left   = total[28:0] - 29'd10;
                  parse_phase = PH_ID3_SKIP;
               end
            end
         end
         PH_ID3_SKIP: begin
            hdr_pos = hdr_pos + 29'd1;
            if (skip_left != 29'd0)
               skip_left = skip_left - 29'd1;
            if (skip_left == 29'd0)
               header_done();
         end
         // FLAC block header: last flag, then 24-bit big-endian length
         PH_FLAC_HDR: begin
            if (skip_left == 29'd4)
               final_blk = (b & LAST_BLOCK_FLAG) != 8'd0;
            else
               size_acc = {4'd0, size_acc[15:0], b};
            hdr_pos = hdr_pos + 29'd1;
            if (skip_left != 29'd0)
               skip_left = skip_left - 29'd1;
            if (skip_left == 29'd0) begin
               blk_end = {3'd0, hdr_pos} + {8'd0, size_acc[23:0]};
               if (final_blk) begin
                  if (blk_end > {8'd0, limit_bytes}) begin
                     header_too_long();
                  end else if (size_acc == 28'd0) begin
                     header_done();
                  end else begin
                     skip_left   = {5'd0, size_acc[23:0]};
                     parse_phase = PH_FLAC_SKIP;
                  end
               end else begin
                  if (blk_end + 32'd4 > {8'd0, limit_bytes}) begin
                     header_too_long();
                  end else if (size_acc == 28'd0) begin
                     open_flac_block();
                  end else begin
                     skip_left   = {5'd0, size_acc[23:0]};
                     parse_phase = PH_FLAC_SKIP;
                  end
               end
            end
         end
         PH_FLAC_SKIP: begin
            hdr_pos = hdr_pos + 29'd1;
            if (skip_left != 29'd0)
               skip_left = skip_left - 29'd1;
            if (skip_left == 29'd0) begin
               if (final_blk)
                  header_done();
               else
                  open_flac_block();
            end
         end
         PH_PASS: add_result(ST_PAYLOAD, b, 29'd0);
         default: ;
      endcase
      if (step_count > 0) begin
         r = step_out[step_count - 1];
         r.last = 1'b1;
         step_out[step_count - 1] = r;
      end
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   function automatic void check_field(input string name, input logic [28:0] want,
                                       input logic [28:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_result();
      result_type want;
      results_checked++;
      if (due_results.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual status %0d byte %02h len %0d",
                  $time, rsp_status, rsp_out_byte, rsp_skipped_length);
         mismatch_count++;
      end else begin
         want = due_results.pop_front();
         check_field("status", {27'd0, want.status}, {27'd0, rsp_status});
         check_field("out_byte", {21'd0, want.out_byte}, {21'd0, rsp_out_byte});
         check_field("skipped_length", want.skipped_length, rsp_skipped_length);
         check_field("last", {28'd0, want.last}, {28'd0, rsp_last});
      end
   endfunction

   // sample handshakes at the edge, before the block updates
   always @(posedge clock) begin
      if (reset) begin
         parse_phase    = PH_PREFIX;
         marker_held[0] = 8'd0;
         marker_held[1] = 8'd0;
         marker_held[2] = 8'd0;
         hdr_pos        = 29'd0;
         skip_left      = 29'd0;
         size_acc       = 28'd0;
         footer_flag    = 1'b0;
         final_blk      = 1'b0;
         limit_bytes    = LIMIT_RESET;
         due_results.delete();
      end else begin
         if (rsp_pop && !rsp_empty)
            check_result();
         if (csr_valid && csr_ready) begin
            limit_bytes = csr_wdata;
            limit_writes++;
         end
         if (req_push && !req_full) begin
            bytes_accepted++;
            strip_byte(req_data_byte);
            if (beat_typed) begin
               due_results.push_back(beat_want);
            end else begin
               for (int i = 0; i < step_count; i++)
                  due_results.push_back(step_out[i]);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------

   function automatic void add_row(input logic is_write, input logic [23:0] value,
                                   input logic typed, input logic [1:0] st,
                                   input logic [7:0] ob, input logic [28:0] len);
      stim_row_type row;
      row.is_write            = is_write;
      row.value               = value;
      row.typed               = typed;
      row.want.status         = st;
      row.want.out_byte       = ob;
      row.want.skipped_length = len;
      row.want.last           = 1'b1;
      stim_table.push_back(row);
   endfunction

   function automatic void header_row(input logic [7:0] b);
      add_row(1'b0, {16'd0, b}, 1'b0, ST_PAYLOAD, 8'd0, 29'd0);
   endfunction

   function automatic void echo_row(input logic [7:0] b);
      add_row(1'b0, {16'd0, b}, 1'b1, ST_PAYLOAD, b, 29'd0);
   endfunction

   function automatic void limit_row(input logic [23:0] v);
      add_row(1'b1, v, 1'b0, ST_PAYLOAD, 8'd0, 29'd0);
   endfunction

   function automatic logic [7:0] noisy_msb(input logic [6:0] low);
      logic [7:0] r;
      r = 8'($urandom);
      return {r[7], low};
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic typed, input result_type want);
      int gap;
      if (items_sent % 40 == 0 && $urandom_range(0, 2) == 0)
         send_burst_left = 40;
      items_sent++;
      gap = 0;
      if (send_burst_left > 0)
         send_burst_left--;
      else
         gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      beat_typed    <= typed;
      beat_want     <= want;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_plain(input logic [7:0] b);
      send_byte(b, 1'b0, '0);
   endtask

   task automatic wait_all_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [23:0] v);
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // random limit write, then well-formed ID3 or FLAC headers with random content, or a broken marker
   task automatic send_random_header();
      int unsigned sub;
      int unsigned blocks;
      int unsigned body;
      int unsigned k;
      logic [23:0] len;
      logic [7:0]  flags;
      logic [7:0]  sz;
      logic [7:0]  rb;
      logic [7:0]  mark [4];
      case ($urandom_range(0, 3))
         0: write_limit(24'($urandom_range(10, 90)));
         1: write_limit(LIMIT_MAX);
         default: write_limit(24'($urandom_range(100, 5000)));
      endcase
      sub = $urandom_range(0, 9);
      if (sub < 4) begin
         send_plain(CH_I);
         send_plain(CH_D);
         send_plain(CH_3);
         send_plain(8'($urandom));
         send_plain(8'($urandom));
         flags = 8'($urandom);
         send_plain(flags);
         sz = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 40));
         send_plain(noisy_msb(7'd0));
         send_plain(noisy_msb(7'd0));
         send_plain(noisy_msb({6'd0, sz[7]}));
         send_plain(noisy_msb(sz[6:0]));
         body = sz + ((flags & FOOTER_FLAG) != 8'd0 ? 10 : 0);
         for (int i = 0; i < body; i++)
            send_plain(8'($urandom));
      end else if (sub < 8) begin
         send_plain(CH_F_LOW);
         send_plain(CH_L);
         send_plain(CH_A_LOW);
         send_plain(CH_C);
         blocks = $urandom_range(1, 5);
         for (int i = 0; i < blocks; i++) begin
            // limit change between blocks applies to later checks
            if (i > 0 && $urandom_range(0, 3) == 0)
               write_limit($urandom_range(0, 1) ? 24'($urandom_range(10, 200)) : LIMIT_MAX);
            rb = 8'($urandom);
            send_plain({i == blocks - 1, rb[6:0]});
            len = ($urandom_range(0, 15) == 0) ? 24'($urandom_range(256, 300))
                                                : 24'($urandom_range(0, 20));
            send_plain(len[23:16]);
            send_plain(len[15:8]);
            send_plain(len[7:0]);
            for (int j = 0; j < len; j++)
               send_plain(8'($urandom));
         end
      end else begin
         // marker broken at a random position
         rb = 8'($urandom);
         if (rb[0]) begin
            mark[0] = CH_I;
            mark[1] = CH_D;
            mark[2] = CH_3;
            mark[3] = CH_C;
            k = $urandom_range(0, 2);
         end else begin
            mark[0] = CH_F_LOW;
            mark[1] = CH_L;
            mark[2] = CH_A_LOW;
            mark[3] = CH_C;
            k = $urandom_range(0, 3);
         end
         for (int i = 0; i < k; i++)
            send_plain(mark[i]);
         do rb = 8'($urandom);
         while (rb == mark[k] || (k == 0 && (rb == CH_I || rb == CH_F_LOW)));
         send_plain(rb);
      end
   endtask

   // result side
   initial begin
      int gap;
      rsp_pop = 1'b0;
      wait (!reset);
      forever begin
         if (stall_request) begin
            // long hold-off so the block backs up into its input
            stall_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end
         if (results_checked % 40 == 0 && $urandom_range(0, 2) == 0)
            rcv_burst_left = 40;
         gap = 0;
         if (rcv_burst_left > 0)
            rcv_burst_left--;
         else
            gap = $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // input and register side
   initial begin
      stim_row_type row;
      int           payload_count;
      logic         silent;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_data_byte = 8'd0;
      csr_valid     = 1'b0;
      csr_wdata     = 24'd0;
      beat_typed    = 1'b0;
      beat_want     = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      case ($urandom_range(0, 7))
         0: stream_kind = STREAM_ID3;
         1: stream_kind = STREAM_FLAC;
         2: stream_kind = STREAM_PLAIN;
         3: stream_kind = STREAM_OVERSIZE;
         default: stream_kind = STREAM_RANDOM;
      endcase

      // directed streams
      case (stream_kind)
         STREAM_ID3: begin
            // footer flag, size bytes with the top bit set, header exactly at the limit
            limit_row(LIMIT_MAX);
            limit_row(24'd21);
            header_row(CH_I);
            header_row(CH_D);
            header_row(CH_3);
            header_row(8'h04);
            header_row(8'h00);
            header_row(FOOTER_FLAG);
            header_row(8'h80);
            header_row(8'h80);
            header_row(8'h80);
            header_row(8'h81);
            for (int i = 0; i < 10; i++)
               header_row(i[0] ? 8'h00 : 8'hFF);
            add_row(1'b0, 24'h0000A5, 1'b1, ST_SKIPPED, 8'd0, 29'd21);
            echo_row(8'h00);
            echo_row(8'hFF);
            echo_row(CH_I);
         end
         STREAM_FLAC: begin
            // zero-length block, limit change mid-header, zero-length last block
            limit_row(LIMIT_MAX);
            header_row(CH_F_LOW);
            header_row(CH_L);
            header_row(CH_A_LOW);
            header_row(CH_C);
            header_row(8'h00);
            header_row(8'h00);
            header_row(8'h00);
            header_row(8'h00);
            limit_row(24'd30);
            header_row(8'h7F);
            header_row(8'h00);
            header_row(8'h00);
            header_row(8'h02);
            header_row(8'hAA);
            header_row(8'h55);
            header_row(8'hFF);
            header_row(8'h00);
            header_row(8'h00);
            add_row(1'b0, 24'd0, 1'b1, ST_SKIPPED, 8'd0, 29'd18);
            echo_row(8'hFF);
            echo_row(8'h00);
         end
         STREAM_PLAIN: begin
            // marker broken on its last byte: held bytes come out first
            limit_row(LIMIT_MAX);
            limit_row(LIMIT_MIN);
            header_row(CH_F_LOW);
            header_row(CH_L);
            header_row(CH_A_LOW);
            header_row(8'h00);
            echo_row(CH_I);
            echo_row(CH_F_LOW);
            echo_row(8'h00);
            echo_row(8'hFF);
         end
         STREAM_OVERSIZE: begin
            // last block ends one byte past the limit, then silence
            limit_row(LIMIT_MAX);
            limit_row(LIMIT_MIN);
            header_row(CH_F_LOW);
            header_row(CH_L);
            header_row(CH_A_LOW);
            header_row(CH_C);
            header_row(LAST_BLOCK_FLAG);
            header_row(8'h00);
            header_row(8'h00);
            add_row(1'b0, 24'd3, 1'b1, ST_TOO_LONG, 8'd0, 29'd0);
            header_row(8'hFF);
            header_row(8'h00);
            header_row(CH_I);
         end
         default: ;
      endcase

      if (stream_kind == STREAM_RANDOM) begin
         send_random_header();
      end else begin
         foreach (stim_table[r]) begin
            row = stim_table[r];
            if (row.is_write)
               write_limit(row.value);
            else
               send_byte(row.value[7:0], row.typed, row.want);
         end
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      silent = (parse_phase == PH_DEAD);

      // payload: random bytes, with one full drain and one long result stall unless the header failed
      payload_count = ITEM_TARGET - items_sent;
      if (payload_count < 40)
         payload_count = 40;
      for (int i = 0; i < payload_count; i++) begin
         if (!silent && i == payload_count / 4)
            stall_request = 1'b1;
         if (!silent && i == payload_count / 2)
            wait_all_results();
         send_plain(8'($urandom));
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Stream %s: %0d bytes accepted, %0d results checked, %0d limit writes.",
               stream_kind.name(), bytes_accepted, results_checked, limit_writes);
      $display("Parser ended in %s with limit %0d.", parse_phase.name(), limit_bytes);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding.", due_results.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
rtl/achs_pkg.sv
rtl/achs_front.sv
rtl/achs_queue.sv
rtl/achs_back.sv
rtl/audio_container_header_stripper.sv
dv/tb_audio_container_header_stripper.sv
